>>> src/ezr_pkg.sv
// shared types, constants and arithmetic helpers for the euler zyx vector rotator
package ezr_pkg;

   localparam int COMP_WIDTH = 16;
   localparam int ANGLE_WIDTH = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int MAX_STAGES = 24;

   localparam int TRIG_Q = 28;
   localparam int CORD_W = 33;
   localparam int TRIG_W = 30;
   localparam int MAT_W = 31;
   localparam int PROD_W = COMP_WIDTH + MAT_W;
   localparam int ACC_W = PROD_W + 2;
   localparam int RND_W = ACC_W - TRIG_Q;

   localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] vec_x;
      logic signed [COMP_WIDTH-1:0] vec_y;
      logic signed [COMP_WIDTH-1:0] vec_z;
      logic [ANGLE_WIDTH-1:0] angle_x;
      logic [ANGLE_WIDTH-1:0] angle_y;
      logic [ANGLE_WIDTH-1:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] rot_x;
      logic signed [COMP_WIDTH-1:0] rot_y;
      logic signed [COMP_WIDTH-1:0] rot_z;
      logic saturated;
   } rsp_type;

   typedef logic [8:0][MAT_W-1:0] mat_type;
   typedef logic [2:0][COMP_WIDTH-1:0] vec_type;

   // atan(2^-i) in turn units, 2^32 is one turn
   function automatic logic [CORD_W-1:0] atan_turns(input int i);
      logic [CORD_W-1:0] t;
      case (i)
         0: t = 33'd536870912;
         1: t = 33'd316933406;
         2: t = 33'd167458907;
         3: t = 33'd85004756;
         4: t = 33'd42667331;
         5: t = 33'd21354465;
         6: t = 33'd10679838;
         7: t = 33'd5340245;
         8: t = 33'd2670163;
         9: t = 33'd1335087;
         10: t = 33'd667544;
         11: t = 33'd333772;
         12: t = 33'd166886;
         13: t = 33'd83443;
         14: t = 33'd41722;
         15: t = 33'd20861;
         16: t = 33'd10430;
         17: t = 33'd5215;
         18: t = 33'd2608;
         19: t = 33'd1304;
         20: t = 33'd652;
         21: t = 33'd326;
         22: t = 33'd163;
         23: t = 33'd81;
         default: t = '0;
      endcase
      return t;
   endfunction

   // q28 product rounded half up back to q28
   function automatic logic signed [MAT_W-1:0] rnd_mul(input logic signed [MAT_W-1:0] a,
                                                       input logic signed [MAT_W-1:0] b);
      logic signed [2*MAT_W-1:0] p;
      p = a * b;
      p = p + ((2*MAT_W)'(1) <<< (TRIG_Q - 1));
      return MAT_W'(p >>> TRIG_Q);
   endfunction

endpackage

>>> src/ezr_cordic_lane.sv
// pipelined rotation-mode cordic lane producing q28 cosine and sine of a binary angle
module ezr_cordic_lane #(
   parameter int STAGES = ezr_pkg::CORDIC_STAGES
) (
   input  logic clock,
   input  logic en,
   input  logic [ezr_pkg::ANGLE_WIDTH-1:0] angle,
   output logic signed [ezr_pkg::TRIG_W-1:0] cos_q,
   output logic signed [ezr_pkg::TRIG_W-1:0] sin_q
);
   import ezr_pkg::*;

   localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

   logic signed [CORD_W-1:0] x_ff [0:N];
   logic signed [CORD_W-1:0] y_ff [0:N];
   logic signed [CORD_W-1:0] z_ff [0:N];
   logic [1:0] q_ff [0:N];
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;

   logic [ANGLE_WIDTH-1:0] shifted, resid;
   logic [1:0] quad_in;
   logic signed [CORD_W-1:0] z_in;
   logic signed [CORD_W-1:0] cx, sy, cx_r, sy_r;

   // quadrant from the top bits after a one-eighth turn offset
   always_comb begin
      shifted = angle + ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 3));
      quad_in = shifted[ANGLE_WIDTH-1 -: 2];
      resid = angle - {quad_in, {(ANGLE_WIDTH-2){1'b0}}};
      z_in = CORD_W'($signed(resid)) <<< (32 - ANGLE_WIDTH);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= z_in;
         q_ff[0] <= quad_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][CORD_W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - $signed(atan_turns(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + $signed(atan_turns(i));
            end
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   always_comb begin
      case (q_ff[N])
         2'd1: begin cx = -y_ff[N]; sy = x_ff[N]; end
         2'd2: begin cx = -x_ff[N]; sy = -y_ff[N]; end
         2'd3: begin cx = y_ff[N]; sy = -x_ff[N]; end
         default: begin cx = x_ff[N]; sy = y_ff[N]; end
      endcase
      cx_r = (cx + CORD_W'(2)) >>> 2;
      sy_r = (sy + CORD_W'(2)) >>> 2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= TRIG_W'(cx_r);
         sin_ff <= TRIG_W'(sy_r);
      end
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

>>> src/ezr_matrix.sv
// two-stage builder of the rz*ry*rx rotation matrix from lane sines and cosines
module ezr_matrix (
   input  logic clock,
   input  logic en,
   input  logic signed [ezr_pkg::TRIG_W-1:0] cx,
   input  logic signed [ezr_pkg::TRIG_W-1:0] sx,
   input  logic signed [ezr_pkg::TRIG_W-1:0] cy,
   input  logic signed [ezr_pkg::TRIG_W-1:0] sy,
   input  logic signed [ezr_pkg::TRIG_W-1:0] cz,
   input  logic signed [ezr_pkg::TRIG_W-1:0] sz,
   output ezr_pkg::mat_type mat
);
   import ezr_pkg::*;

   logic signed [MAT_W-1:0] ecx, esx, ecy, esy, ecz, esz;
   logic signed [MAT_W-1:0] czsy_ff, szsy_ff, czcy_ff, szcy_ff, cysx_ff, cycx_ff;
   logic signed [MAT_W-1:0] szcx_ff, czcx_ff, szsx_ff, czsx_ff, sx_ff, cx_ff, nsy_ff;
   mat_type mat_ff;

   assign ecx = MAT_W'(cx);
   assign esx = MAT_W'(sx);
   assign ecy = MAT_W'(cy);
   assign esy = MAT_W'(sy);
   assign ecz = MAT_W'(cz);
   assign esz = MAT_W'(sz);

   always_ff @(posedge clock) begin
      if (en) begin
         czsy_ff <= rnd_mul(ecz, esy);
         szsy_ff <= rnd_mul(esz, esy);
         czcy_ff <= rnd_mul(ecz, ecy);
         szcy_ff <= rnd_mul(esz, ecy);
         cysx_ff <= rnd_mul(ecy, esx);
         cycx_ff <= rnd_mul(ecy, ecx);
         szcx_ff <= rnd_mul(esz, ecx);
         czcx_ff <= rnd_mul(ecz, ecx);
         szsx_ff <= rnd_mul(esz, esx);
         czsx_ff <= rnd_mul(ecz, esx);
         sx_ff <= esx;
         cx_ff <= ecx;
         nsy_ff <= -esy;
      end
   end

   // second level: triple products folded into the cross terms
   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff[0] <= czcy_ff;
         mat_ff[1] <= rnd_mul(czsy_ff, sx_ff) - szcx_ff;
         mat_ff[2] <= szsx_ff + rnd_mul(czsy_ff, cx_ff);
         mat_ff[3] <= szcy_ff;
         mat_ff[4] <= czcx_ff + rnd_mul(szsy_ff, sx_ff);
         mat_ff[5] <= rnd_mul(szsy_ff, cx_ff) - czsx_ff;
         mat_ff[6] <= nsy_ff;
         mat_ff[7] <= cysx_ff;
         mat_ff[8] <= cycx_ff;
      end
   end

   assign mat = mat_ff;

endmodule

>>> src/ezr_merge.sv
// matrix-vector product, rounding and saturation into the result register
module ezr_merge (
   input  logic clock,
   input  logic en,
   input  ezr_pkg::vec_type vec,
   input  ezr_pkg::mat_type mat,
   output ezr_pkg::rsp_type rsp
);
   import ezr_pkg::*;

   localparam logic signed [RND_W-1:0] HI = RND_W'((1 <<< (COMP_WIDTH - 1)) - 1);
   localparam logic signed [RND_W-1:0] LO = -HI - RND_W'(1);

   logic signed [PROD_W-1:0] prod_ff [0:8];
   logic signed [ACC_W-1:0] acc [0:2];
   logic signed [RND_W-1:0] r [0:2];
   logic [2:0] clip;
   logic signed [COMP_WIDTH-1:0] res [0:2];
   rsp_type rsp_ff;

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         always_ff @(posedge clock) begin
            if (en)
               prod_ff[3*i+j] <= PROD_W'($signed(vec[j])) * PROD_W'($signed(mat[3*i+j]));
         end
      end

      always_comb begin
         acc[i] = ACC_W'(prod_ff[3*i]) + ACC_W'(prod_ff[3*i+1]) + ACC_W'(prod_ff[3*i+2])
                  + (ACC_W'(1) <<< (TRIG_Q - 1));
         r[i] = RND_W'(acc[i] >>> TRIG_Q);
         clip[i] = (r[i] > HI) || (r[i] < LO);
         if (r[i] > HI)
            res[i] = COMP_WIDTH'(HI);
         else if (r[i] < LO)
            res[i] = COMP_WIDTH'(LO);
         else
            res[i] = COMP_WIDTH'(r[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.rot_x <= res[0];
         rsp_ff.rot_y <= res[1];
         rsp_ff.rot_z <= res[2];
         rsp_ff.saturated <= |clip;
      end
   end

   assign rsp = rsp_ff;

endmodule

>>> src/euler_zyx_vector_rotate_core.sv
// top level of the euler zyx vector rotator: cordic lanes, matrix build and merge
// Rotates a signed Q3.12 vector by angles about x, then y, then z (matrix Rz*Ry*Rx).
// One request is taken every cycle unless a result waits on rsp_ready; each result
// passes through the three cordic lanes (one pipeline stage per iteration plus
// reduction and restore stages), two matrix stages and two merge stages. The whole
// pipeline holds while a result waits on rsp_ready.
module euler_zyx_vector_rotate_core #(
   parameter int CORDIC_STAGES = ezr_pkg::CORDIC_STAGES
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ezr_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ezr_pkg::rsp_type rsp_data
);
   import ezr_pkg::*;

   localparam int N = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam int VEC_LAT = N + 4;
   localparam int TOT_LAT = VEC_LAT + 2;

   logic en;
   logic [TOT_LAT-1:0] valid_ff;
   vec_type vec_ff [0:VEC_LAT-1];
   logic signed [TRIG_W-1:0] cx, sx, cy, sy, cz, sz;
   mat_type mat;

   assign en = !valid_ff[TOT_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[TOT_LAT-1];

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (en)
         valid_ff <= {valid_ff[TOT_LAT-2:0], req_valid};
   end

   // vector travels alongside the lanes and the matrix stages
   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff[0] <= {req_data.vec_z, req_data.vec_y, req_data.vec_x};
         for (int k = 1; k < VEC_LAT; k++)
            vec_ff[k] <= vec_ff[k-1];
      end
   end

   ezr_cordic_lane #(.STAGES(N)) u_lane_x (
      .clock(clock), .en(en), .angle(req_data.angle_x), .cos_q(cx), .sin_q(sx));
   ezr_cordic_lane #(.STAGES(N)) u_lane_y (
      .clock(clock), .en(en), .angle(req_data.angle_y), .cos_q(cy), .sin_q(sy));
   ezr_cordic_lane #(.STAGES(N)) u_lane_z (
      .clock(clock), .en(en), .angle(req_data.angle_z), .cos_q(cz), .sin_q(sz));

   ezr_matrix u_matrix (
      .clock(clock), .en(en), .cx(cx), .sx(sx), .cy(cy), .sy(sy), .cz(cz), .sz(sz),
      .mat(mat));

   ezr_merge u_merge (
      .clock(clock), .en(en), .vec(vec_ff[VEC_LAT-1]), .mat(mat), .rsp(rsp_data));

   localparam logic signed [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
   localparam logic signed [COMP_WIDTH-1:0] CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.rot_x == CMAX || rsp_data.rot_x == CMIN ||
          rsp_data.rot_y == CMAX || rsp_data.rot_y == CMIN ||
          rsp_data.rot_z == CMAX || rsp_data.rot_z == CMIN))
      else $error("saturated flag without a clamped component");

   a_result_from_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid || $past(valid_ff[TOT_LAT-2]))
      else $error("result without a matching request");

endmodule

>>> dv/ezr_rotate_checker.sv
// checker for the euler zyx vector rotator: predicts each rotated vector and compares results
module ezr_rotate_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  ezr_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  ezr_pkg::rsp_type rsp_data,
   output int fail_count,
   output int pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ezr_pkg::*;

   rsp_type rotated_q[$];

   localparam longint TURN_ATAN [MAX_STAGES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   // round half up then floor shift
   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint q28_mul(input longint a, input longint b);
      return round_shift(a * b, TRIG_Q);
   endfunction

   function automatic void angle_trig(input logic [ANGLE_WIDTH-1:0] ang,
                                      output longint cosv, output longint sinv);
      logic [ANGLE_WIDTH-1:0] quad_ang, resid;
      logic [1:0] quad;
      longint x, y, z, dx, dy, cx, sy;
      int n;
      quad_ang = ang + ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 3));
      quad = quad_ang[ANGLE_WIDTH-1 -: 2];
      resid = ang - (ANGLE_WIDTH'(quad) << (ANGLE_WIDTH - 2));
      z = longint'($signed(resid)) * (longint'(1) << (32 - ANGLE_WIDTH));
      x = longint'(CORDIC_GAIN);
      y = 0;
      n = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
      for (int i = 0; i < n; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= TURN_ATAN[i];
         end else begin
            x += dx; y -= dy; z += TURN_ATAN[i];
         end
      end
      case (quad)
         2'd1: begin cx = -y; sy = x; end
         2'd2: begin cx = -x; sy = -y; end
         2'd3: begin cx = y; sy = -x; end
         default: begin cx = x; sy = y; end
      endcase
      cosv = round_shift(cx, 30 - TRIG_Q);
      sinv = round_shift(sy, 30 - TRIG_Q);
   endfunction

   function automatic rsp_type rotate_zyx(input req_type r);
      longint v[3], m[3][3], cx, sx, cy, sy, cz, sz, czsy, szsy, acc, res;
      longint hi, lo;
      logic signed [COMP_WIDTH-1:0] comp[3];
      rsp_type o;
      hi = (longint'(1) << (COMP_WIDTH - 1)) - 1;
      lo = -hi - 1;
      v[0] = r.vec_x;
      v[1] = r.vec_y;
      v[2] = r.vec_z;
      angle_trig(r.angle_x, cx, sx);
      angle_trig(r.angle_y, cy, sy);
      angle_trig(r.angle_z, cz, sz);
      czsy = q28_mul(cz, sy);
      szsy = q28_mul(sz, sy);
      m[0][0] = q28_mul(cz, cy);
      m[0][1] = -q28_mul(sz, cx) + q28_mul(czsy, sx);
      m[0][2] = q28_mul(sz, sx) + q28_mul(czsy, cx);
      m[1][0] = q28_mul(sz, cy);
      m[1][1] = q28_mul(cz, cx) + q28_mul(szsy, sx);
      m[1][2] = -q28_mul(cz, sx) + q28_mul(szsy, cx);
      m[2][0] = -sy;
      m[2][1] = q28_mul(cy, sx);
      m[2][2] = q28_mul(cy, cx);
      o.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += v[j] * m[i][j];
         res = round_shift(acc, TRIG_Q);
         if (res > hi) begin res = hi; o.saturated = 1'b1; end
         if (res < lo) begin res = lo; o.saturated = 1'b1; end
         comp[i] = res[COMP_WIDTH-1:0];
      end
      o.rot_x = comp[0];
      o.rot_y = comp[1];
      o.rot_z = comp[2];
      return o;
   endfunction

   initial fail_count = 0;
   assign pending = rotated_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) rotated_q.push_back(rotate_zyx(req_data));
         if (rsp_valid && rsp_ready) begin
            if (rotated_q.size() == 0) begin
               $error("unexpected result %h", rsp_data);
               fail_count++;
            end else begin
               want = rotated_q.pop_front();
               if (rsp_data.rot_x !== want.rot_x) begin
                  $error("rot_x expected %0d actual %0d", want.rot_x, rsp_data.rot_x);
                  fail_count++;
               end
               if (rsp_data.rot_y !== want.rot_y) begin
                  $error("rot_y expected %0d actual %0d", want.rot_y, rsp_data.rot_y);
                  fail_count++;
               end
               if (rsp_data.rot_z !== want.rot_z) begin
                  $error("rot_z expected %0d actual %0d", want.rot_z, rsp_data.rot_z);
                  fail_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated expected %0b actual %0b", want.saturated,
                         rsp_data.saturated);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

>>> dv/tb_euler_zyx_vector_rotate_core.sv
// testbench top for the euler zyx vector rotator: stimulus, receiver stalls and verdict
module tb_euler_zyx_vector_rotate_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ezr_pkg::*;

   localparam int RANDOM_REQS = 1800;
   localparam int PIPE_DEPTH = CORDIC_STAGES + 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   int fail_count;
   int pending;
   bit hold_off = 1'b0;

   always #5 clock = ~clock;

   euler_zyx_vector_rotate_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   ezr_rotate_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   req_type directed_q[$];

   function automatic logic [15:0] pick_comp();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 255)) - 16'd128;
         3: return 16'h1000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_angle();
      logic [15:0] base;
      case ($urandom_range(0, 4))
         // near quadrant and octant boundaries
         0: begin
            base = 16'($urandom_range(0, 7)) << 13;
            return base + 16'($urandom_range(0, 6)) - 16'd3;
         end
         1: return 16'($urandom_range(0, 3)) << 14;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_req(input req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // receiver stall pattern plus one long hold-off
   initial begin
      int mode;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            if (hold_off) rsp_ready <= 1'b0;
            else if (mode == 0) rsp_ready <= 1'b1;
            else if (mode == 1) rsp_ready <= ($urandom_range(0, 3) != 0);
            else if (mode == 2) rsp_ready <= ($urandom_range(0, 3) == 0);
            else rsp_ready <= ~rsp_ready;
            @(posedge clock);
         end
      end
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      req_type r;
      logic [15:0] comps[4];
      logic [15:0] angs[8];
      int gap, burst;
      comps = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
      angs = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h2000, 16'h1fff,
               16'hffff, 16'he000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 8; i++) begin
         r.vec_x = comps[i % 4];
         r.vec_y = comps[(i + 1) % 4];
         r.vec_z = comps[(i + 2) % 4];
         r.angle_x = angs[i];
         r.angle_y = angs[(i + 3) % 8];
         r.angle_z = angs[(i + 5) % 8];
         directed_q.push_back(r);
      end
      // full-scale vectors under 45 degree turns saturate
      directed_q.push_back(req_type'{16'h7fff, 16'h7fff, 16'h7fff, 16'h2000, 16'h2000,
                                     16'h2000});
      directed_q.push_back(req_type'{16'h8000, 16'h8000, 16'h8000, 16'he000, 16'h2000,
                                     16'he000});
      directed_q.push_back(req_type'{16'h7fff, 16'h8000, 16'h7fff, 16'h6000, 16'ha000,
                                     16'h2000});
      directed_q.push_back(req_type'{16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                     16'h4000});
      directed_q.push_back(req_type'{16'h0000, 16'h1000, 16'h0000, 16'h4000, 16'h0000,
                                     16'h0000});
      directed_q.push_back(req_type'{16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h4000,
                                     16'h0000});
      directed_q.push_back(req_type'{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                                     16'haaaa});
      directed_q.push_back(req_type'{16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                                     16'h5555});
      foreach (directed_q[i]) send_req(directed_q[i]);

      for (int n = 0; n < RANDOM_REQS; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < RANDOM_REQS; b++, n++) begin
            r.vec_x = pick_comp();
            r.vec_y = pick_comp();
            r.vec_z = pick_comp();
            r.angle_x = pick_angle();
            r.angle_y = pick_angle();
            r.angle_z = pick_angle();
            send_req(r);
            // long receiver hold-off while requests keep coming
            if (n == 600) begin
               hold_off = 1'b1;
               fork
                  begin
                     repeat (4 * PIPE_DEPTH + 50) @(posedge clock);
                     hold_off = 1'b0;
                  end
               join_none
            end
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // let the checker record the last request before draining
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
